// ===== design/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master register transfer package
// Shared command codes, transfer stage type and bit constants.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] BYTE_MSB  = 8'h80;
    localparam logic [7:0] READ_BIT  = 8'h01;

    typedef enum logic [3:0] {
        ST_IDLE        = 4'd0,
        ST_START       = 4'd1,
        ST_SEND_SLAVE  = 4'd2,
        ST_WACK_SLAVE  = 4'd3,
        ST_SEND_REG    = 4'd4,
        ST_WACK_REG    = 4'd5,
        ST_RSTART      = 4'd6,
        ST_SEND_RSLAVE = 4'd7,
        ST_WACK_RSLAVE = 4'd8,
        ST_SEND_DATA   = 4'd9,
        ST_WACK_DATA   = 4'd10,
        ST_READ        = 4'd11,
        ST_MACK        = 4'd12,
        ST_STOP        = 4'd13
    } t_stage;

endpackage

// ===== design/i2c_master_register_transfer_unit.sv =====
// A transfer passes through the input register, then its result is shown from
// the result register.
// Throughput: one transfer per clock while the result channel does not stall;
// the bus state update is a single pass of logic between the two registers.
// Reset: synchronous, active low; transfer stage goes idle, counters clear,
// held bus levels return to released high, both registers empty.
// ----------------------------------------------------------------------------
// I2C master register transfer unit
// Bit-bang I2C master; each tick transfer advances one bus delay phase.
// ----------------------------------------------------------------------------
module i2c_master_register_transfer_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_slave_addr,
    input  logic [7:0] i_reg_addr,
    input  logic [7:0] i_count,
    input  logic [7:0] i_wdata,
    input  logic       i_sda_in,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_scl,
    output logic       o_sda_out,
    output logic       o_wdata_taken,
    output logic [7:0] o_rdata,
    output logic       o_rdata_valid,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_nack_error,
    output logic       o_cmd_rejected
);

    // input register
    logic       r_in_valid;
    logic [1:0] r_cmd;
    logic [7:0] r_slave_addr;
    logic [7:0] r_reg_addr;
    logic [7:0] r_count;
    logic [7:0] r_wdata;
    logic       r_sda_in;

    // bus state
    i2cm_pkg::t_stage r_stage, n_stage;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_bit_index, n_bit_index;
    logic [7:0] r_shift, n_shift;
    logic [8:0] r_bytes_left, n_bytes_left;
    logic       r_is_read, n_is_read;
    logic [7:0] r_held_slave, n_held_slave;
    logic [7:0] r_held_reg, n_held_reg;
    logic       r_nack_seen, n_nack_seen;
    logic       r_line_scl, n_line_scl;
    logic       r_line_sda, n_line_sda;

    // result values
    logic       n_taken, n_rvalid, n_done, n_nerr, n_rej;
    logic [7:0] n_rbyte;
    logic [7:0] v_shift;
    logic [3:0] v_bit_next;

    logic       advance;

    assign advance = r_in_valid && (!o_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cmd        <= i_cmd;
            r_slave_addr <= i_slave_addr;
            r_reg_addr   <= i_reg_addr;
            r_count      <= i_count;
            r_wdata      <= i_wdata;
            r_sda_in     <= i_sda_in;
        end
    end

    always_comb begin
        n_stage      = r_stage;
        n_phase      = r_phase;
        n_bit_index  = r_bit_index;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_is_read    = r_is_read;
        n_held_slave = r_held_slave;
        n_held_reg   = r_held_reg;
        n_nack_seen  = r_nack_seen;
        n_line_scl   = r_line_scl;
        n_line_sda   = r_line_sda;
        n_taken      = 1'b0;
        n_rvalid     = 1'b0;
        n_rbyte      = 8'h00;
        n_done       = 1'b0;
        n_nerr       = 1'b0;
        n_rej        = 1'b0;
        v_shift      = r_shift;
        v_bit_next   = r_bit_index + 4'd1;

        if (r_cmd == i2cm_pkg::CMD_WRITE || r_cmd == i2cm_pkg::CMD_READ) begin
            if (r_stage == i2cm_pkg::ST_IDLE) begin
                n_held_slave = r_slave_addr;
                n_held_reg   = r_reg_addr;
                n_bytes_left = (r_count == 8'd0) ? 9'd256 : {1'b0, r_count};
                n_is_read    = (r_cmd == i2cm_pkg::CMD_READ);
                n_nack_seen  = 1'b0;
                n_stage      = i2cm_pkg::ST_START;
                n_phase      = 2'd0;
                n_bit_index  = 4'd0;
            end else begin
                n_rej = 1'b1;
            end
        end else if (r_cmd == i2cm_pkg::CMD_TICK) begin
            case (r_stage)
                i2cm_pkg::ST_IDLE: begin
                    n_line_scl = 1'b1;
                    n_line_sda = 1'b1;
                end
                i2cm_pkg::ST_START, i2cm_pkg::ST_RSTART: begin
                    n_line_scl = (r_phase < 2'd2);
                    n_line_sda = (r_phase == 2'd0);
                    if (r_phase >= 2'd2) begin
                        n_stage     = (r_stage == i2cm_pkg::ST_START) ?
                                      i2cm_pkg::ST_SEND_SLAVE : i2cm_pkg::ST_SEND_RSLAVE;
                        n_phase     = 2'd0;
                        n_bit_index = 4'd0;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                i2cm_pkg::ST_SEND_SLAVE, i2cm_pkg::ST_SEND_REG,
                i2cm_pkg::ST_SEND_RSLAVE, i2cm_pkg::ST_SEND_DATA: begin
                    if (r_bit_index == 4'd0 && r_phase == 2'd0) begin
                        case (r_stage)
                            i2cm_pkg::ST_SEND_SLAVE:  v_shift = r_held_slave;
                            i2cm_pkg::ST_SEND_REG:    v_shift = r_held_reg;
                            i2cm_pkg::ST_SEND_RSLAVE:
                                v_shift = r_held_slave + i2cm_pkg::READ_BIT;
                            default: begin
                                v_shift = r_wdata;
                                n_taken = 1'b1;
                            end
                        endcase
                    end
                    n_line_sda = |(v_shift & i2cm_pkg::BYTE_MSB);
                    n_line_scl = (r_phase == 2'd1);
                    n_shift    = v_shift;
                    if (r_phase >= 2'd2) begin
                        n_shift     = {v_shift[6:0], 1'b0};
                        n_bit_index = v_bit_next;
                        n_phase     = 2'd0;
                        if (v_bit_next >= 4'd8) begin
                            n_bit_index = 4'd0;
                            case (r_stage)
                                i2cm_pkg::ST_SEND_SLAVE:  n_stage = i2cm_pkg::ST_WACK_SLAVE;
                                i2cm_pkg::ST_SEND_REG:    n_stage = i2cm_pkg::ST_WACK_REG;
                                i2cm_pkg::ST_SEND_RSLAVE: n_stage = i2cm_pkg::ST_WACK_RSLAVE;
                                default:                  n_stage = i2cm_pkg::ST_WACK_DATA;
                            endcase
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                i2cm_pkg::ST_WACK_SLAVE, i2cm_pkg::ST_WACK_REG,
                i2cm_pkg::ST_WACK_RSLAVE, i2cm_pkg::ST_WACK_DATA: begin
                    n_line_sda = 1'b1;
                    n_line_scl = (r_phase == 2'd1 || r_phase == 2'd2);
                    if (r_phase == 2'd2 && r_sda_in) begin
                        n_nack_seen = 1'b1;
                    end
                    if (r_phase == 2'd3) begin
                        n_phase     = 2'd0;
                        n_bit_index = 4'd0;
                        if (r_nack_seen) begin
                            n_stage = i2cm_pkg::ST_STOP;
                        end else begin
                            case (r_stage)
                                i2cm_pkg::ST_WACK_SLAVE: n_stage = i2cm_pkg::ST_SEND_REG;
                                i2cm_pkg::ST_WACK_REG:
                                    n_stage = r_is_read ? i2cm_pkg::ST_RSTART
                                                        : i2cm_pkg::ST_SEND_DATA;
                                i2cm_pkg::ST_WACK_RSLAVE: n_stage = i2cm_pkg::ST_READ;
                                default: begin
                                    if (r_bytes_left != 9'd0) begin
                                        n_bytes_left = r_bytes_left - 9'd1;
                                    end
                                    n_stage = (r_bytes_left <= 9'd1) ?
                                              i2cm_pkg::ST_STOP : i2cm_pkg::ST_SEND_DATA;
                                end
                            endcase
                        end
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                i2cm_pkg::ST_READ: begin
                    n_line_sda = 1'b1;
                    if (r_phase == 2'd0) begin
                        n_line_scl = 1'b0;
                        n_shift    = 8'h00;
                        n_phase    = 2'd1;
                    end else if (r_phase == 2'd1) begin
                        n_line_scl = 1'b1;
                        n_shift    = {r_shift[6:0], r_sda_in};
                        n_phase    = 2'd2;
                    end else begin
                        n_line_scl  = 1'b0;
                        n_bit_index = v_bit_next;
                        n_phase     = 2'd1;
                        if (v_bit_next >= 4'd8) begin
                            n_rbyte  = r_shift;
                            n_rvalid = 1'b1;
                            if (r_bytes_left != 9'd0) begin
                                n_bytes_left = r_bytes_left - 9'd1;
                            end
                            n_stage     = i2cm_pkg::ST_MACK;
                            n_phase     = 2'd0;
                            n_bit_index = 4'd0;
                        end
                    end
                end
                i2cm_pkg::ST_MACK: begin
                    n_line_sda = (r_bytes_left == 9'd0);
                    n_line_scl = (r_phase == 2'd1);
                    if (r_phase >= 2'd2) begin
                        n_stage     = (r_bytes_left != 9'd0) ?
                                      i2cm_pkg::ST_READ : i2cm_pkg::ST_STOP;
                        n_phase     = 2'd0;
                        n_bit_index = 4'd0;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                i2cm_pkg::ST_STOP: begin
                    n_line_scl = (r_phase != 2'd0);
                    n_line_sda = (r_phase >= 2'd2);
                    if (r_phase >= 2'd2) begin
                        n_done      = 1'b1;
                        n_nerr      = r_nack_seen;
                        n_stage     = i2cm_pkg::ST_IDLE;
                        n_phase     = 2'd0;
                        n_bit_index = 4'd0;
                    end else begin
                        n_phase = r_phase + 2'd1;
                    end
                end
                default: begin
                    n_stage     = i2cm_pkg::ST_IDLE;
                    n_phase     = 2'd0;
                    n_bit_index = 4'd0;
                    n_line_scl  = 1'b1;
                    n_line_sda  = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= i2cm_pkg::ST_IDLE;
            r_phase      <= 2'd0;
            r_bit_index  <= 4'd0;
            r_shift      <= 8'h00;
            r_bytes_left <= 9'd0;
            r_is_read    <= 1'b0;
            r_held_slave <= 8'h00;
            r_held_reg   <= 8'h00;
            r_nack_seen  <= 1'b0;
            r_line_scl   <= 1'b1;
            r_line_sda   <= 1'b1;
        end else if (advance) begin
            r_stage      <= n_stage;
            r_phase      <= n_phase;
            r_bit_index  <= n_bit_index;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_is_read    <= n_is_read;
            r_held_slave <= n_held_slave;
            r_held_reg   <= n_held_reg;
            r_nack_seen  <= n_nack_seen;
            r_line_scl   <= n_line_scl;
            r_line_sda   <= n_line_sda;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (!o_valid || !i_stall) begin
            o_valid <= r_in_valid;
        end
        if (advance) begin
            o_scl          <= n_line_scl;
            o_sda_out      <= n_line_sda;
            o_wdata_taken  <= n_taken;
            o_rdata        <= n_rbyte;
            o_rdata_valid  <= n_rvalid;
            o_busy_res     <= (n_stage != i2cm_pkg::ST_IDLE);
            o_done_res     <= n_done;
            o_nack_error   <= n_nerr;
            o_cmd_rejected <= n_rej;
        end
    end

endmodule

// ===== design/i2cm_checker.sv =====
// ----------------------------------------------------------------------------
// I2C master register transfer checker
// Port-level consistency checks on the result channel.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_scl,
    input logic       o_sda_out,
    input logic       o_wdata_taken,
    input logic [7:0] o_rdata,
    input logic       o_rdata_valid,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_nack_error,
    input logic       o_cmd_rejected
);

    logic xfer;
    assign xfer = o_valid && !i_stall;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && o_done_res |-> !o_busy_res && o_scl && o_sda_out)
        else $error("done without released bus or idle");

    a_nack_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && o_nack_error |-> o_done_res)
        else $error("nack error without done");

    a_rdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && !o_rdata_valid |-> o_rdata == 8'h00)
        else $error("rdata nonzero without valid");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && o_cmd_rejected |-> o_busy_res && !o_done_res && !o_rdata_valid)
        else $error("rejected command while idle");

    a_taken_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xfer && o_wdata_taken |-> o_busy_res && !o_rdata_valid)
        else $error("write byte taken outside a transfer");

endmodule

bind i2c_master_register_transfer_unit i2cm_checker u_i2cm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_scl          (o_scl),
    .o_sda_out      (o_sda_out),
    .o_wdata_taken  (o_wdata_taken),
    .o_rdata        (o_rdata),
    .o_rdata_valid  (o_rdata_valid),
    .o_busy_res     (o_busy_res),
    .o_done_res     (o_done_res),
    .o_nack_error   (o_nack_error),
    .o_cmd_rejected (o_cmd_rejected)
);
